### sv/omae_pkg.sv
package omae_pkg;

    localparam int INDEX_WIDTH = 16;
    localparam int WORD_WIDTH  = 16;

    // Character codes of the operand syntax.
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Addressing modes.
    localparam logic [2:0] MODE_REG         = 3'b000;
    localparam logic [2:0] MODE_DEF         = 3'b001;
    localparam logic [2:0] MODE_AUTOINC     = 3'b010;
    localparam logic [2:0] MODE_AUTOINC_DEF = 3'b011;
    localparam logic [2:0] MODE_AUTODEC     = 3'b100;
    localparam logic [2:0] MODE_AUTODEC_DEF = 3'b101;
    localparam logic [2:0] MODE_INDEXED     = 3'b110;
    localparam logic [2:0] MODE_INDEXED_DEF = 3'b111;

    localparam logic [3:0] MAX_REG = 4'd7;
    localparam logic [3:0] REG_SAT = 4'd8;

    typedef enum logic [11:0] {
        PH_START       = 12'b0000_0000_0001,
        PH_AT          = 12'b0000_0000_0010,
        PH_MINUS       = 12'b0000_0000_0100,
        PH_INDEX       = 12'b0000_0000_1000,
        PH_LPAREN      = 12'b0000_0001_0000,
        PH_REG_R       = 12'b0000_0010_0000,
        PH_REG_DIGITS  = 12'b0000_0100_0000,
        PH_BARE_R      = 12'b0000_1000_0000,
        PH_BARE_DIGITS = 12'b0001_0000_0000,
        PH_RPAREN      = 12'b0010_0000_0000,
        PH_PLUS_DONE   = 12'b0100_0000_0000,
        PH_ERROR       = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    // The index word is the low bits of the index (zero without an index or on
    // an error), whatever width the index is accumulated at.
    typedef struct packed {
        logic                  parse_error;
        logic [5:0]            specifier;
        logic                  has_index;
        logic [WORD_WIDTH-1:0] index_word;
    } result_item_t;

endpackage

### sv/operand_addressing_mode_encoder_core.sv
// Channel   Valid          Stall          Payload
// input     char_valid     char_stall     char_data   (omae_pkg::char_item_t)
// output    result_valid   result_stall   result_data (omae_pkg::result_item_t)
//
// One character is taken per cycle while char_stall is low; the character that ends the token
// passes through the input register, then its result is loaded into the result register.
// Reset clears the parse state and both valid flags.
// Characters keep flowing while a result waits; only a token's last character
// waits for the result register to empty.
module operand_addressing_mode_encoder_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_stall,
    input  omae_pkg::char_item_t   char_data,
    output logic                   result_valid,
    input  logic                   result_stall,
    output omae_pkg::result_item_t result_data
);

    logic                   in_valid_reg, in_valid_next;
    omae_pkg::char_item_t   in_data_reg, in_data_next;
    logic                   accept;
    logic                   fire;
    omae_pkg::result_item_t parse_result;

    // A last character needs a free result register; others never wait.
    assign fire = in_valid_reg &&
                  (!in_data_reg.last_char || !result_valid || !result_stall);
    assign char_stall = in_valid_reg && !fire;
    assign accept = char_valid && !char_stall;

    always_comb
    begin
        in_valid_next = accept || (in_valid_reg && !fire);
        in_data_next  = accept ? char_data : in_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        in_data_reg <= in_data_next;
    end

    omae_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (fire),
        .item   (in_data_reg),
        .result (parse_result)
    );

    omae_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && in_data_reg.last_char),
        .load_data (parse_result),
        .stall     (result_stall),
        .valid     (result_valid),
        .data      (result_data)
    );

    a_nonlast_flows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !in_data_reg.last_char |-> !char_stall)
        else $error("non-final character held back");

endmodule

### sv/omae_parser.sv
module omae_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  omae_pkg::char_item_t  item,
    output omae_pkg::result_item_t result
);

    omae_pkg::phase_t                 phase_reg, phase_next;
    logic                             deferred_reg, deferred_next;
    logic                             predec_reg, predec_next;
    logic                             index_form_reg, index_form_next;
    logic                             index_neg_reg, index_neg_next;
    logic [omae_pkg::INDEX_WIDTH-1:0] index_acc_reg, index_acc_next;
    logic [3:0]                       reg_acc_reg, reg_acc_next;
    logic                             digits_reg, digits_next;

    // Values after this character, before the end-of-token clear.
    omae_pkg::phase_t                 ph_a;
    logic                             def_a, pre_a, idxf_a, neg_a, dig_a;
    logic [omae_pkg::INDEX_WIDTH-1:0] acc_a, acc_step, idx_val;
    logic [3:0]                       reg_a, reg_step;
    logic [6:0]                       reg_wide;
    logic [7:0]                       c;
    logic                             is_dig;
    logic [3:0]                       d;
    logic                             ok;
    logic [2:0]                       mode;

    always_comb
    begin
        c        = item.char_code;
        is_dig   = (c >= omae_pkg::CH_ZERO) && (c <= omae_pkg::CH_NINE);
        d        = c[3:0];
        acc_step = (index_acc_reg << 3) + (index_acc_reg << 1)
                   + omae_pkg::INDEX_WIDTH'(d);
        reg_wide = 7'(reg_acc_reg) * 7'd10 + 7'(d);
        reg_step = ((reg_acc_reg >= omae_pkg::REG_SAT) || (reg_wide > 7'(omae_pkg::REG_SAT)))
                   ? omae_pkg::REG_SAT : reg_wide[3:0];

        ph_a   = omae_pkg::PH_ERROR;
        def_a  = deferred_reg;
        pre_a  = predec_reg;
        idxf_a = index_form_reg;
        neg_a  = index_neg_reg;
        acc_a  = index_acc_reg;
        reg_a  = reg_acc_reg;
        dig_a  = digits_reg;

        case (phase_reg)
            omae_pkg::PH_START, omae_pkg::PH_AT:
            begin
                if (c == omae_pkg::CH_R && phase_reg == omae_pkg::PH_START)
                    ph_a = omae_pkg::PH_BARE_R;
                else if (c == omae_pkg::CH_LPAREN)
                    ph_a = omae_pkg::PH_LPAREN;
                else if (c == omae_pkg::CH_AT && phase_reg == omae_pkg::PH_START)
                begin
                    def_a = 1'b1;
                    ph_a  = omae_pkg::PH_AT;
                end
                else if (c == omae_pkg::CH_MINUS)
                    ph_a = omae_pkg::PH_MINUS;
                else if (c == omae_pkg::CH_PLUS)
                begin
                    idxf_a = 1'b1;
                    ph_a   = omae_pkg::PH_INDEX;
                end
                else if (is_dig)
                begin
                    idxf_a = 1'b1;
                    acc_a  = acc_step;
                    dig_a  = 1'b1;
                    ph_a   = omae_pkg::PH_INDEX;
                end
            end
            omae_pkg::PH_MINUS:
            begin
                if (c == omae_pkg::CH_LPAREN)
                begin
                    pre_a = 1'b1;
                    ph_a  = omae_pkg::PH_LPAREN;
                end
                else if (is_dig)
                begin
                    idxf_a = 1'b1;
                    neg_a  = 1'b1;
                    acc_a  = acc_step;
                    dig_a  = 1'b1;
                    ph_a   = omae_pkg::PH_INDEX;
                end
            end
            omae_pkg::PH_INDEX:
            begin
                if (is_dig)
                begin
                    acc_a = acc_step;
                    dig_a = 1'b1;
                    ph_a  = omae_pkg::PH_INDEX;
                end
                else if (c == omae_pkg::CH_LPAREN && digits_reg)
                    ph_a = omae_pkg::PH_LPAREN;
            end
            omae_pkg::PH_LPAREN:
            begin
                if (c == omae_pkg::CH_R)
                    ph_a = omae_pkg::PH_REG_R;
            end
            omae_pkg::PH_REG_R, omae_pkg::PH_REG_DIGITS:
            begin
                if (is_dig)
                begin
                    reg_a = reg_step;
                    ph_a  = omae_pkg::PH_REG_DIGITS;
                end
                else if (c == omae_pkg::CH_RPAREN && phase_reg == omae_pkg::PH_REG_DIGITS)
                    ph_a = omae_pkg::PH_RPAREN;
            end
            omae_pkg::PH_BARE_R, omae_pkg::PH_BARE_DIGITS:
            begin
                if (is_dig)
                begin
                    reg_a = reg_step;
                    ph_a  = omae_pkg::PH_BARE_DIGITS;
                end
            end
            omae_pkg::PH_RPAREN:
            begin
                if (c == omae_pkg::CH_PLUS && !index_form_reg && !predec_reg)
                    ph_a = omae_pkg::PH_PLUS_DONE;
            end
            default:
            begin
                ph_a = omae_pkg::PH_ERROR;
            end
        endcase

        // Classify the finished token.
        ok   = 1'b1;
        mode = omae_pkg::MODE_REG;
        if (ph_a == omae_pkg::PH_BARE_DIGITS)
            mode = omae_pkg::MODE_REG;
        else if (ph_a == omae_pkg::PH_RPAREN)
        begin
            if (idxf_a)
                mode = def_a ? omae_pkg::MODE_INDEXED_DEF : omae_pkg::MODE_INDEXED;
            else if (pre_a)
                mode = def_a ? omae_pkg::MODE_AUTODEC_DEF : omae_pkg::MODE_AUTODEC;
            else if (def_a)
                ok = 1'b0;
            else
                mode = omae_pkg::MODE_DEF;
        end
        else if (ph_a == omae_pkg::PH_PLUS_DONE)
            mode = def_a ? omae_pkg::MODE_AUTOINC_DEF : omae_pkg::MODE_AUTOINC;
        else
            ok = 1'b0;
        if (reg_a > omae_pkg::MAX_REG)
            ok = 1'b0;

        idx_val = neg_a ? (~acc_a + omae_pkg::INDEX_WIDTH'(1)) : acc_a;

        result.parse_error = !ok;
        result.specifier   = ok ? {mode, reg_a[2:0]} : 6'd0;
        result.has_index   = ok && idxf_a;
        result.index_word  = (ok && idxf_a) ? omae_pkg::WORD_WIDTH'(idx_val) : '0;

        phase_next      = phase_reg;
        deferred_next   = deferred_reg;
        predec_next     = predec_reg;
        index_form_next = index_form_reg;
        index_neg_next  = index_neg_reg;
        index_acc_next  = index_acc_reg;
        reg_acc_next    = reg_acc_reg;
        digits_next     = digits_reg;
        if (step)
        begin
            if (item.last_char)
            begin
                phase_next      = omae_pkg::PH_START;
                deferred_next   = 1'b0;
                predec_next     = 1'b0;
                index_form_next = 1'b0;
                index_neg_next  = 1'b0;
                index_acc_next  = '0;
                reg_acc_next    = 4'd0;
                digits_next     = 1'b0;
            end
            else
            begin
                phase_next      = ph_a;
                deferred_next   = def_a;
                predec_next     = pre_a;
                index_form_next = idxf_a;
                index_neg_next  = neg_a;
                index_acc_next  = acc_a;
                reg_acc_next    = reg_a;
                digits_next     = dig_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= omae_pkg::PH_START;
            deferred_reg   <= 1'b0;
            predec_reg     <= 1'b0;
            index_form_reg <= 1'b0;
            index_neg_reg  <= 1'b0;
            index_acc_reg  <= '0;
            reg_acc_reg    <= 4'd0;
            digits_reg     <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            deferred_reg   <= deferred_next;
            predec_reg     <= predec_next;
            index_form_reg <= index_form_next;
            index_neg_reg  <= index_neg_next;
            index_acc_reg  <= index_acc_next;
            reg_acc_reg    <= reg_acc_next;
            digits_reg     <= digits_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_char |=> phase_reg == omae_pkg::PH_START && reg_acc_reg == 4'd0)
        else $error("parser state not cleared after the last character");

    a_reg_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        reg_acc_reg <= omae_pkg::REG_SAT)
        else $error("register accumulator above its saturation value");

    a_index_needs_form: assert property (@(posedge clk) disable iff (!rst_n)
        digits_reg |-> index_form_reg)
        else $error("index digits recorded outside an indexed form");

endmodule

### sv/omae_out_buf.sv
module omae_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  omae_pkg::result_item_t load_data,
    input  logic                   stall,
    output logic                   valid,
    output omae_pkg::result_item_t data
);

    logic                   valid_reg, valid_next;
    omae_pkg::result_item_t data_reg, data_next;

    always_comb
    begin
        valid_next = load || (valid_reg && stall);
        data_next  = load ? load_data : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(valid_reg && stall))
        else $error("result overwritten while still waiting for transfer");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.parse_error |->
            data_reg.specifier == 6'd0 && !data_reg.has_index && data_reg.index_word == '0)
        else $error("error result carries nonzero fields");

endmodule
